FILE: rtl/crcfr_pkg.sv
// ----------------------------------------------------------------------------
// crcfr_pkg
// Shared types, status codes and the CRC-16/XMODEM byte update for the
// framed packet receiver.
// ----------------------------------------------------------------------------
package crcfr_pkg;

  // End of frame status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_HEADER = 3'd1,
    ST_BAD_CRC    = 3'd2,
    ST_BAD_LENGTH = 3'd3,
    ST_OVERFLOW   = 3'd4
  } status_t;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_END     = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_HEADER_FIRST  = 2'd0;
  localparam logic [1:0] REG_HEADER_SECOND = 2'd1;

  localparam logic [7:0]  HEADER_FIRST_RESET  = 8'h5a;
  localparam logic [7:0]  HEADER_SECOND_RESET = 8'ha5;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'h0000;

  // One result beat
  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [6:0] byte_index;
    status_t    status;
    logic [15:0] crc_value;
  } result_t;

  // Feed one byte into a CRC-16/XMODEM remainder, MSB first
  function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/crcfr_front.sv
// ----------------------------------------------------------------------------
// crcfr_front
// Accepts received bytes, tracks the frame position, runs the CRC and
// builds at most one result beat per byte for the result queue.
// ----------------------------------------------------------------------------
module crcfr_front #(
  parameter int FRAME_LIMIT = 128
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [1:0]           cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 in_take,
  input  logic [7:0]           byte_in,
  output logic                 res_push,
  output crcfr_pkg::result_t   res
);

  localparam logic [8:0] LIMIT = 9'(FRAME_LIMIT);

  logic [7:0]  header_first;
  logic [7:0]  header_second;
  logic [7:0]  byte_count, byte_count_next;
  logic [6:0]  payload_length, payload_length_next;
  logic [15:0] running_crc, running_crc_next;
  logic        header_seen_ok, header_seen_ok_next;
  logic [7:0]  first_crc_byte, first_crc_byte_next;

  logic [8:0]  cnt_inc;
  logic [8:0]  len_ext;
  logic [6:0]  idx_full;
  logic [15:0] crc_fed;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      header_first  <= crcfr_pkg::HEADER_FIRST_RESET;
      header_second <= crcfr_pkg::HEADER_SECOND_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        crcfr_pkg::REG_HEADER_FIRST:  header_first  <= cfg_data;
        crcfr_pkg::REG_HEADER_SECOND: header_second <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cnt_inc  = {1'b0, byte_count} + 9'd1;
  assign len_ext  = {2'b00, payload_length};
  assign idx_full = cnt_inc[6:0] - 7'd4;
  assign crc_fed  = crcfr_pkg::crc16_feed(running_crc, byte_in);

  // Classify the byte by its frame position
  always_comb begin
    byte_count_next     = byte_count;
    payload_length_next = payload_length;
    running_crc_next    = running_crc;
    header_seen_ok_next = header_seen_ok;
    first_crc_byte_next = first_crc_byte;
    res_push            = 1'b0;
    res                 = '0;
    if (in_take) begin
      if (cnt_inc >= LIMIT) begin
        // Drop the byte, report overflow and restart
        res_push            = 1'b1;
        res.kind            = crcfr_pkg::KIND_END;
        res.status          = crcfr_pkg::ST_OVERFLOW;
        byte_count_next     = '0;
        payload_length_next = '0;
        running_crc_next    = crcfr_pkg::CRC_INIT;
        header_seen_ok_next = 1'b0;
        first_crc_byte_next = '0;
      end else begin
        byte_count_next = cnt_inc[7:0];
        if (cnt_inc == 9'd1) begin
          header_seen_ok_next = (byte_in == header_first);
          running_crc_next    = crc_fed;
        end else if (cnt_inc == 9'd2) begin
          header_seen_ok_next = header_seen_ok && (byte_in == header_second);
          running_crc_next    = crc_fed;
        end else if (cnt_inc == 9'd3) begin
          // Zero marks a zero or negative length
          payload_length_next = byte_in[7] ? 7'd0 : byte_in[6:0];
          running_crc_next    = crc_fed;
        end else if (payload_length == 7'd0) begin
          res_push            = 1'b1;
          res.kind            = crcfr_pkg::KIND_END;
          res.status          = crcfr_pkg::ST_BAD_LENGTH;
          byte_count_next     = '0;
          payload_length_next = '0;
          running_crc_next    = crcfr_pkg::CRC_INIT;
          header_seen_ok_next = 1'b0;
          first_crc_byte_next = '0;
        end else if (cnt_inc <= len_ext + 9'd3) begin
          // Payload byte: pass it on with its index
          running_crc_next = crc_fed;
          res_push         = 1'b1;
          res.kind         = crcfr_pkg::KIND_PAYLOAD;
          res.data_byte    = byte_in;
          res.byte_index   = idx_full;
        end else if (cnt_inc == len_ext + 9'd4) begin
          first_crc_byte_next = byte_in;
        end else begin
          // Last byte: check header, then CRC
          res_push  = 1'b1;
          res.kind  = crcfr_pkg::KIND_END;
          res.crc_value = running_crc;
          if (!header_seen_ok) begin
            res.status = crcfr_pkg::ST_BAD_HEADER;
          end else if ({first_crc_byte, byte_in} != running_crc) begin
            res.status = crcfr_pkg::ST_BAD_CRC;
          end else begin
            res.status = crcfr_pkg::ST_OK;
          end
          byte_count_next     = '0;
          payload_length_next = '0;
          running_crc_next    = crcfr_pkg::CRC_INIT;
          header_seen_ok_next = 1'b0;
          first_crc_byte_next = '0;
        end
      end
    end
  end

  // Frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      payload_length <= '0;
      running_crc    <= crcfr_pkg::CRC_INIT;
      header_seen_ok <= 1'b0;
      first_crc_byte <= '0;
    end else begin
      byte_count     <= byte_count_next;
      payload_length <= payload_length_next;
      running_crc    <= running_crc_next;
      header_seen_ok <= header_seen_ok_next;
      first_crc_byte <= first_crc_byte_next;
    end
  end

  // Every end beat leaves a cleared frame behind
  a_end_restarts: assert property (@(posedge clk) disable iff (rst)
    res_push && res.kind == crcfr_pkg::KIND_END |=>
      byte_count == 8'd0 && running_crc == crcfr_pkg::CRC_INIT && !header_seen_ok)
    else $error("frame state not cleared after end beat");

  // The count stays below the frame limit
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    {1'b0, byte_count} < LIMIT)
    else $error("byte count reached frame limit");

  // Payload beats only come after the length byte
  a_payload_pos: assert property (@(posedge clk) disable iff (rst)
    res_push && res.kind == crcfr_pkg::KIND_PAYLOAD |-> byte_count >= 8'd3)
    else $error("payload beat before length byte");

endmodule

FILE: rtl/crcfr_queue.sv
// ----------------------------------------------------------------------------
// crcfr_queue
// Short result queue between the byte front end and the result port.
// Holds beats until the receiver pops them.
// ----------------------------------------------------------------------------
module crcfr_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  crcfr_pkg::result_t wr_data,
  input  logic               pop,
  output logic               full,
  output logic               empty,
  output crcfr_pkg::result_t rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  crcfr_pkg::result_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = slots[rd_ptr];

  // Store a beat
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: ;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("queue occupancy beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    do_push && !do_pop |=> count == $past(count) + CNT_W'(1))
    else $error("queue occupancy did not grow on push");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == FULL_CNT) |-> wr_ptr == rd_ptr)
    else $error("queue pointers disagree with occupancy");

endmodule

FILE: rtl/crc16_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// crc16_frame_receiver_unit
// Framed packet receiver with CRC-16/XMODEM check.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes enter on byte_in with push; a byte is taken when push is high and
//   full is low. Frames are two header bytes, a signed length byte, the
//   payload and two CRC bytes, high byte first.
//   Results leave as a queue: while empty is low the oldest beat sits on
//   kind, data_byte, byte_index, status and crc_value; pop takes it.
//   Each payload byte gives a payload beat; the last byte of a frame, the
//   byte after a bad length byte or an overflowing byte gives one end beat.
//   One byte is taken every cycle while full is low; its beat, if any, is
//   written to the result queue as it is taken. The whole CRC byte update
//   is combinational, so throughput is one byte per clock while full is low.
//   When the receiver stops popping, the result queue (QUEUE_DEPTH beats)
//   fills and full rises; bytes that produce no beat are still held back
//   then.
//   Reset clears the frame state and the queue and loads the header
//   registers with 0x5a and 0xa5. Header writes on cfg_write take effect
//   on the next byte; an index beyond the two registers is ignored.
// ----------------------------------------------------------------------------
module crc16_frame_receiver_unit #(
  parameter int FRAME_LIMIT = 128,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  byte_in,
  output logic        empty,
  input  logic        pop,
  output logic        kind,
  output logic [7:0]  data_byte,
  output logic [6:0]  byte_index,
  output logic [2:0]  status,
  output logic [15:0] crc_value
);

  logic               in_take;
  logic               res_push;
  crcfr_pkg::result_t res;
  crcfr_pkg::result_t head;

  assign in_take = push && !full;

  // Byte front end
  crcfr_front #(
    .FRAME_LIMIT(FRAME_LIMIT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_take   (in_take),
    .byte_in   (byte_in),
    .res_push  (res_push),
    .res       (res)
  );

  // Result queue
  crcfr_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (res_push),
    .wr_data (res),
    .pop     (pop),
    .full    (full),
    .empty   (empty),
    .rd_data (head)
  );

  assign kind       = head.kind;
  assign data_byte  = head.data_byte;
  assign byte_index = head.byte_index;
  assign status     = head.status;
  assign crc_value  = head.crc_value;

endmodule
